[rtl/lsh_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 cross sharpening filter.
// No dependencies; every other file in rtl/ imports this package.
package lsh_pkg;

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 11;
    localparam int FW_W        = 12;
    localparam int FH_W        = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int OUT_DATA_W  = 32;
    localparam int MIN_DIM     = 3;
    localparam int H_MAX       = 4096;
    localparam int PIX_MAX     = 255;
    localparam int KERNEL_GAIN = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // One classified pixel, handed from the line-store front to the kernel back end
    typedef struct packed {
        logic [PIX_W-1:0] centre;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] pix;
        logic [ROW_W-1:0] row;      // row of the incoming pixel
        logic [COL_W-1:0] col;
        logic             border;   // result for row-1 is a border pixel
        logic             two;      // last row: a second, zero result follows
        logic             last_col;
    } t_item;

endpackage

[rtl/lsh_front.sv]
`timescale 1ns / 1ps
// Front end: pixel intake, row/column counters, the two line stores and
// classification of each pixel. Depends on lsh_pkg.
module lsh_front import lsh_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [FW_W-1:0]  i_frame_width,
    input  logic [FH_W-1:0]  i_frame_height,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_full,
    output logic             o_push,
    output t_item            o_item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW >= FW_W) ? CW + 1 : FW_W + 1;

    logic [WW-1:0]    w_ext;
    logic [WW-1:0]    w_eff;
    logic [CW-1:0]    w_m1;
    logic [FH_W-1:0]  h_eff;
    logic [ROW_W-1:0] h_m1;

    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_s1_valid, n_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic [CW-1:0]    r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_has_res;
    logic             r_s1_border;
    logic             r_s1_two;
    logic             r_s1_last_col;
    logic [PIX_W-1:0] r_left;

    logic [PIX_W-1:0] r_line_mid [MAX_WIDTH];
    logic [PIX_W-1:0] r_line_up  [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_centre;
    logic [PIX_W-1:0] r_rd_right;
    logic [PIX_W-1:0] r_rd_up;

    logic             accept;
    logic             drain;
    logic             last_col;
    logic             last_row;
    logic [ROW_W-1:0] row_up;
    logic             border;
    logic [CW-1:0]    addr_right;

    // Effective frame size, clamped to the supported range
    always_comb begin
        w_ext = WW'(i_frame_width);
        if (w_ext < WW'(MIN_DIM)) begin
            w_eff = WW'(MIN_DIM);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        w_m1 = CW'(w_eff - WW'(1));

        if (i_frame_height < FH_W'(MIN_DIM)) begin
            h_eff = FH_W'(MIN_DIM);
        end else if (i_frame_height > FH_W'(H_MAX)) begin
            h_eff = FH_W'(H_MAX);
        end else begin
            h_eff = i_frame_height;
        end
        h_m1 = ROW_W'(h_eff - FH_W'(1));
    end

    assign o_ready = !r_s1_valid || !i_full;
    assign accept  = i_valid && o_ready;
    assign drain   = r_s1_valid && !i_full;
    assign o_push  = drain && r_s1_has_res;

    assign last_col   = r_col >= w_m1;
    assign last_row   = r_row >= h_m1;
    assign row_up     = r_row - ROW_W'(1);
    assign border     = (row_up == '0) || (row_up >= h_m1) || (r_col == '0) || last_col;
    assign addr_right = (r_col == CW'(MAX_WIDTH - 1)) ? '0 : r_col + CW'(1);

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_s1_valid = r_s1_valid;
        if (drain) begin
            n_s1_valid = 1'b0;
        end
        if (accept) begin
            n_s1_valid = 1'b1;
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_left     <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= n_s1_valid;
            if (drain) begin
                r_left <= r_rd_centre;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= i_pixel;
            r_s1_col      <= r_col;
            r_s1_row      <= r_row;
            r_s1_has_res  <= r_row != '0;
            r_s1_border   <= border;
            r_s1_two      <= last_row;
            r_s1_last_col <= last_col;
        end
    end

    // Middle line store: read centre and right neighbour, write the new pixel
    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_line_mid[r_s1_col] <= r_s1_pix;
        end
        if (accept) begin
            r_rd_centre <= r_line_mid[r_col];
            r_rd_right  <= r_line_mid[addr_right];
        end
    end

    // Upper line store: the old middle row moves up
    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_line_up[r_s1_col] <= r_rd_centre;
        end
        if (accept) begin
            r_rd_up <= r_line_up[r_col];
        end
    end

    always_comb begin
        o_item.centre   = r_rd_centre;
        o_item.left     = r_left;
        o_item.right    = r_rd_right;
        o_item.up       = r_rd_up;
        o_item.pix      = r_s1_pix;
        o_item.row      = r_s1_row;
        o_item.col      = COL_W'(r_s1_col);
        o_item.border   = r_s1_border;
        o_item.two      = r_s1_two;
        o_item.last_col = r_s1_last_col;
    end

endmodule

[rtl/lsh_queue.sv]
`timescale 1ns / 1ps
// Short queue of classified pixels between the front end and the back end.
// Depends on lsh_pkg.
module lsh_queue import lsh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

endmodule

[rtl/lsh_back.sv]
`timescale 1ns / 1ps
// Back end: kernel arithmetic, saturation, border zeroing and the output
// register; expands last-row pixels into two results. Depends on lsh_pkg.
module lsh_back import lsh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_item            i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_value,
    output logic [ROW_W-1:0] o_row,
    output logic [COL_W-1:0] o_col,
    output logic             o_last
);

    logic [PIX_W+2:0]        gain_c;
    logic [PIX_W+1:0]        nb_sum;
    logic signed [PIX_W+3:0] diff;
    logic [PIX_W-1:0]        sharp;

    logic             load;
    logic             r_valid, n_valid;
    logic             r_phase, n_phase;
    logic [PIX_W-1:0] r_value, n_value;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col;
    logic             r_last, n_last;

    always_comb begin
        gain_c = (PIX_W+3)'(i_item.centre) * (PIX_W+3)'(KERNEL_GAIN);
        nb_sum = (PIX_W+2)'(i_item.left) + (PIX_W+2)'(i_item.right)
               + (PIX_W+2)'(i_item.up) + (PIX_W+2)'(i_item.pix);
        diff   = signed'((PIX_W+4)'(gain_c) - (PIX_W+4)'(nb_sum));
        if (diff < 0) begin
            sharp = '0;
        end else if (diff > (PIX_W+4)'(PIX_MAX)) begin
            sharp = PIX_W'(PIX_MAX);
        end else begin
            sharp = diff[PIX_W-1:0];
        end
    end

    assign load  = i_valid && (!r_valid || i_ready);
    assign o_pop = load && (r_phase || !i_item.two);

    always_comb begin
        n_valid = r_valid;
        n_phase = r_phase;
        n_value = r_value;
        n_row   = r_row;
        n_last  = r_last;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
            if (r_phase) begin
                // zero border result of the last row itself
                n_value = '0;
                n_row   = i_item.row;
                n_last  = i_item.last_col;
                n_phase = 1'b0;
            end else begin
                n_value = i_item.border ? '0 : sharp;
                n_row   = i_item.row - ROW_W'(1);
                n_last  = 1'b0;
                n_phase = i_item.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_row   <= n_row;
        r_last  <= n_last;
        if (load) begin
            r_col <= i_item.col;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_last  = r_last;

endmodule

[rtl/laplacian_sharpen_3x3.sv]
`timescale 1ns / 1ps
// Top level of the 3x3 cross sharpening filter: configuration registers and
// the front end, queue and back end. Depends on lsh_pkg, lsh_front, lsh_queue, lsh_back.
//
// Usage:
//   Slave stream (i_s_*): one 8-bit grayscale pixel per word, raster order.
//   Master stream (o_m_*): one result per word: sharpened value
//     (5*centre - left - right - up - down, saturated to 0..255) with its row
//     and column; border pixels come out as zero. tlast marks the final
//     result of the frame.
//   Config channel (i_cfg_*): index 0 = frame width, index 1 = frame height.
//     Always ready; write only between frames or while the block is drained.
// Timing:
//   Results lag one row: the result for row r-1 passes through the front stage
//   register, the queue and the output register after the pixel of row r at
//   the same column is accepted. The first row yields no result. One pixel per
//   cycle is accepted while the output drains; in the last row each pixel
//   yields two results (row above, then the zero border of the last row), so
//   that row runs at a lower pixel rate, set by the single output register.
// Reset: synchronous, active low; counters, queue and output valid clear,
//   width/height return to 640x480. The line stores are not cleared.
// Stall: when i_m_tready is low the output word holds, the queue fills and
//   then o_s_tready drops until the receiver takes words again.
module laplacian_sharpen_3x3 import lsh_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [PIX_W-1:0]      i_s_tdata,    // [7:0] pixel_value
    // master stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,    // [7:0] out_value, [19:8] out_row,
                                                // [30:20] out_col, [31] zero
    output logic                  o_m_tlast,    // frame_last
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;

    logic             push;
    logic             full;
    logic             pop;
    logic             q_valid;
    t_item            front_item;
    t_item            head_item;
    logic [PIX_W-1:0] out_value;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;

    // Configuration registers; the port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: count, read and update the line stores, classify
    lsh_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_pixel        (i_s_tdata),
        .i_full         (full),
        .o_push         (push),
        .o_item         (front_item)
    );

    // Decouple the two halves so each can stall on its own
    lsh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    // Back: kernel, saturation, result expansion and output register
    lsh_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (head_item),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_value (out_value),
        .o_row   (out_row),
        .o_col   (out_col),
        .o_last  (o_m_tlast)
    );

    // Pack the word: value lowest, then row, then column, zero-filled
    assign o_m_tdata = {1'b0, out_col, out_row, out_value};

endmodule

[rtl/lsh_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the sharpening filter, bound to the top level.
// Depends on lsh_pkg and laplacian_sharpen_3x3.
module lsh_checker import lsh_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tlast
);

    // Hold a stalled output word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled output word changed");

    // Drop valid after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // First column and first row are border: value must be zero
    a_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[30:20] == 11'd0 || o_m_tdata[19:8] == 12'd0)
        |-> o_m_tdata[7:0] == 8'd0)
        else $error("border pixel not zero");

    // Frame end lies on the last row, which is all border
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[7:0] == 8'd0 && o_m_tdata[31] == 1'b0)
        else $error("frame end word not a zero border pixel");

endmodule

bind laplacian_sharpen_3x3 lsh_checker u_lsh_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for laplacian_sharpen_3x3: drives pixel frames of many sizes,
// predicts every sharpened word and compares it field by field. Depends on lsh_pkg.
module testbench;
    import lsh_pkg::*;

    localparam int LINE_MAX          = 2048;   // line store depth of the DUT instance
    localparam int SETTLE_CYCLES     = 8;      // quiet time before a register write
    localparam int TAIL_CYCLES       = 20;     // quiet time after the last result
    localparam int LONG_STALL        = 400;    // receiver hold-off, long enough to back up
    localparam int QUIET_LIMIT       = 4000;   // cycles with no word moving anywhere
    localparam int RANDOM_PIXELS     = 1000;
    localparam int ERROR_PRINT_LIMIT = 40;

    typedef enum {FILL_NOISE, FILL_BINARY, FILL_RAMP, FILL_PEAK, FILL_PIT} fill_t;
    typedef enum {RX_OPEN, RX_LIGHT, RX_HALF, RX_SPARSE} rx_mode_t;

    // One sharpened word as it leaves the filter.
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } sharp_result_t;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [PIX_W-1:0]      i_s_tdata   = '0;     // [7:0] pixel_value
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;            // [7:0] value, [19:8] row, [30:20] col
    logic                  o_m_tlast;            // frame_last
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    laplacian_sharpen_3x3 #(
        .MAX_WIDTH(LINE_MAX)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the registers, line stores and
    // raster counters, all at their reset values.
    // ------------------------------------------------------------------
    logic [FW_W-1:0]  frame_w_reg = FRAME_WIDTH_RST;
    logic [FH_W-1:0]  frame_h_reg = FRAME_HEIGHT_RST;
    bit [PIX_W-1:0]   line_above  [LINE_MAX];
    bit [PIX_W-1:0]   line_middle [LINE_MAX];
    bit [PIX_W-1:0]   left_pix    = '0;
    int unsigned      row_idx     = 0;
    int unsigned      col_idx     = 0;

    sharp_result_t    sharp_expected_q[$];
    logic [PIX_W-1:0] pix_pending[$];

    int unsigned pixels_queued   = 0;
    int unsigned pixels_accepted = 0;
    int unsigned fail_count      = 0;
    int unsigned quiet_cycles    = 0;
    bit          pix_taken       = 1'b0;   // set at the edge that takes a pixel word
    bit          long_stall_armed = 1'b0;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo,
                                              int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the filter by one accepted pixel and queue the words it causes:
    // none on row 0, the row above on the middle rows, and on the last row
    // the row above followed by the zero border word of the last row itself.
    task automatic sharpen_pixel(input bit [PIX_W-1:0] pix);
        int unsigned   w, h, c, r;
        bit            last_col, last_row, border;
        bit [PIX_W-1:0] up, centre, right;
        int            acc;
        sharp_result_t res;
        w = clamp_dim(32'(frame_w_reg), MIN_DIM, LINE_MAX);
        h = clamp_dim(32'(frame_h_reg), MIN_DIM, H_MAX);
        c = col_idx;
        r = row_idx;
        last_col = (c >= w - 1);
        last_row = (r >= h - 1);
        up     = line_above[c];
        centre = line_middle[c];
        right  = (c + 1 < LINE_MAX) ? line_middle[c + 1] : '0;
        if (r >= 1) begin
            border = (r - 1 == 0) || (r - 1 >= h - 1) || (c == 0) || last_col;
            acc = 0;
            if (!border) begin
                acc = KERNEL_GAIN * int'(centre) - int'(left_pix) - int'(right)
                      - int'(up) - int'(pix);
                if (acc < 0) acc = 0;
                if (acc > PIX_MAX) acc = PIX_MAX;
            end
            res.value = PIX_W'(acc);
            res.row   = ROW_W'(r - 1);
            res.col   = COL_W'(c);
            res.last  = 1'b0;
            sharp_expected_q.push_back(res);
            if (last_row) begin
                res.value = '0;
                res.row   = ROW_W'(r);
                res.last  = last_col;
                sharp_expected_q.push_back(res);
            end
        end
        // shift the window: this centre becomes the next left neighbor
        left_pix       = centre;
        line_above[c]  = centre;
        line_middle[c] = pix;
        if (last_col) begin
            col_idx = 0;
            row_idx = last_row ? 0 : r + 1;
        end else begin
            col_idx = c + 1;
        end
    endtask

    function automatic void check_field(string name, int unsigned want, logic [31:0] got);
        if (got !== 32'(want)) begin
            fail_count++;
            if (fail_count <= ERROR_PRINT_LIMIT)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both streams and the config channel at the rising
    // edge, check leaving words, feed accepted pixels to the predictor and
    // run the watchdog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        bit            moved;
        sharp_result_t want;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                moved = 1'b1;
                if (sharp_expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= ERROR_PRINT_LIMIT)
                        $error("unexpected word: row %0d col %0d value %0d",
                               o_m_tdata[PIX_W +: ROW_W],
                               o_m_tdata[PIX_W + ROW_W +: COL_W], o_m_tdata[PIX_W-1:0]);
                end else begin
                    want = sharp_expected_q.pop_front();
                    check_field("out_value", 32'(want.value), 32'(o_m_tdata[PIX_W-1:0]));
                    check_field("out_row", 32'(want.row), 32'(o_m_tdata[PIX_W +: ROW_W]));
                    check_field("out_col", 32'(want.col),
                                32'(o_m_tdata[PIX_W + ROW_W +: COL_W]));
                    check_field("frame_last", 32'(want.last), 32'(o_m_tlast));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                moved = 1'b1;
                sharpen_pixel(i_s_tdata);
                pixels_accepted++;
                pix_taken = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) moved = 1'b1;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Pixel driver: offer words from the pending queue in bursts with random
    // gaps. Hold a word until it is taken; change only on the falling edge.
    // ------------------------------------------------------------------
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || pix_taken) begin
            pix_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (pix_pending.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pix_pending.pop_front();
                if (burst_left <= 1) begin
                    // some bursts run long with no gap at all
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: switch between stall patterns of random length; once armed,
    // hold off for a long stretch so the filter backs up into its input.
    // ------------------------------------------------------------------
    rx_mode_t    rx_mode       = RX_OPEN;
    int unsigned rx_mode_left  = 0;
    int unsigned rx_tick       = 0;
    int unsigned hold_off_left = 0;

    always @(negedge i_clk) begin
        if (long_stall_armed && o_m_tvalid) begin
            long_stall_armed = 1'b0;
            hold_off_left    = LONG_STALL;
        end
        rx_tick++;
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 160);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_OPEN:  i_m_tready <= 1'b1;
                RX_LIGHT: i_m_tready <= ($urandom_range(0, 3) != 0);
                RX_HALF:  i_m_tready <= 1'($urandom_range(0, 1));
                default:  i_m_tready <= (rx_tick % 3 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_FRAME_WIDTH) frame_w_reg = data[FW_W-1:0];
        else                        frame_h_reg = data[FH_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Set the frame size, push one whole frame, then drain: pause the
    // sender until every expected word has left, and let the block settle.
    task automatic run_frame(input logic [CFG_DATA_W-1:0] wdata,
                             input logic [CFG_DATA_W-1:0] hdata, input fill_t fill);
        int unsigned    w, h;
        bit [PIX_W-1:0] base, pix;
        write_reg(CFG_FRAME_WIDTH, wdata);
        write_reg(CFG_FRAME_HEIGHT, hdata);
        w    = clamp_dim(32'(wdata[FW_W-1:0]), MIN_DIM, LINE_MAX);
        h    = clamp_dim(32'(hdata[FH_W-1:0]), MIN_DIM, H_MAX);
        base = PIX_W'($urandom);
        for (int unsigned r = 0; r < h; r++) begin
            for (int unsigned c = 0; c < w; c++) begin
                case (fill)
                    FILL_NOISE:  pix = PIX_W'($urandom);
                    FILL_BINARY: pix = $urandom_range(0, 1) ? PIX_W'(PIX_MAX) : '0;
                    FILL_RAMP:   pix = base + PIX_W'(r * 3 + c * 5);
                    FILL_PEAK:   pix = (r == 1 && c == 1) ? PIX_W'(PIX_MAX) : '0;
                    default:     pix = (r == 1 && c == 1) ? '0 : PIX_W'(PIX_MAX);
                endcase
                pix_pending.push_back(pix);
                pixels_queued++;
            end
        end
        while (pixels_accepted != pixels_queued || sharp_expected_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned           random_pixels;
        int unsigned           sel;
        logic [CFG_DATA_W-1:0] wdata, hdata;
        fill_t                 fill;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Directed: a lone bright pixel saturates high, a lone dark pixel in
        // a bright field saturates low; the second frame also clamps a width
        // and a height below the minimum up to three.
        run_frame(13'd3, 13'd3, FILL_PEAK);
        run_frame(13'd0, 13'd1, FILL_PIT);

        // A wide frame whose width write carries a set top bit that must be
        // dropped; back up the output on it. Then a narrow, tall frame.
        long_stall_armed = 1'b1;
        run_frame(13'h1078, 13'd3, FILL_NOISE);
        run_frame(13'd1, 13'd10, FILL_RAMP);

        // Random frames, mostly small, some clamped from below.
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            sel = $urandom_range(0, 19);
            wdata = {1'($urandom), 12'(sel < 14 ? $urandom_range(3, 12) :
                                       sel < 17 ? $urandom_range(13, 40) :
                                                  $urandom_range(0, 2))};
            sel = $urandom_range(0, 19);
            hdata = 13'(sel < 14 ? $urandom_range(3, 8) :
                        sel < 17 ? $urandom_range(9, 16) : $urandom_range(0, 2));
            sel = $urandom_range(0, 3);
            fill = (sel < 2) ? FILL_NOISE : (sel == 2) ? FILL_BINARY : FILL_RAMP;
            random_pixels += clamp_dim(32'(wdata[FW_W-1:0]), MIN_DIM, LINE_MAX)
                             * clamp_dim(32'(hdata), MIN_DIM, H_MAX);
            run_frame(wdata, hdata, fill);
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && sharp_expected_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/lsh_pkg.sv
rtl/lsh_front.sv
rtl/lsh_queue.sv
rtl/lsh_back.sv
rtl/laplacian_sharpen_3x3.sv
rtl/lsh_checker.sv
bench/testbench.sv
